>>> design/bmhq_pkg.sv
// Shared types and constants of the binary min-heap queue.
// Standalone package; imported by the top level, the checker and the testbench.
package bmhq_pkg;

  localparam int KEY_W  = 31;
  localparam int TAG_W  = 16;
  localparam int FILL_W = 11;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_UP     = 6'b000010,
    ST_UP_FIN = 6'b000100,
    ST_EXT    = 6'b001000,
    ST_DN     = 6'b010000,
    ST_DN_FIN = 6'b100000
  } state_t;

  typedef struct packed {
    logic              found;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic              dropped;
    logic [FILL_W-1:0] fill;
  } result_t;

endpackage

>>> design/bmhq_entry_ram.sv
// Heap entry store: one write port, two read ports, registered read data.
// No dependencies.
module bmhq_entry_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 47
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_a_addr,
  input  logic [AW-1:0] rd_b_addr,
  output logic [DW-1:0] rd_a_data,
  output logic [DW-1:0] rd_b_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

>>> design/binary_min_heap_queue_unit.sv
// Results: insert results are registered on acceptance, extract results in ST_EXT.
// Occupancy: the walk takes one heap level per step (one memory read, compare, write
//   each). One item at a time; a new beat is taken once the heap walk has finished
//   and no result is held under out_stall.
// Reset (synchronous, rst_n low) empties the heap by clearing the entry count;
//   the entry memory is not cleared, so no clearing pass is needed.
module binary_min_heap_queue_unit #(
  parameter int DEPTH    = 1024,
  parameter int TAG_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [bmhq_pkg::KEY_W-1:0]    in_entry_key,
  input  logic [bmhq_pkg::TAG_W-1:0]    in_entry_tag,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_out_valid,
  output logic [bmhq_pkg::KEY_W-1:0]    out_out_key,
  output logic [bmhq_pkg::TAG_W-1:0]    out_out_tag,
  output logic                          out_insert_dropped,
  output logic [bmhq_pkg::FILL_W-1:0]   out_fill_count
);

  import bmhq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // memory address
  localparam int CW = $clog2(DEPTH + 1);                 // entry count
  localparam int XW = AW + 2;                            // child index math
  localparam int DW = KEY_W + TAG_BITS;                  // {key, tag}

  // control state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_vld_r, out_vld_nxt;
  // payload
  logic [AW-1:0]   pos_r, pos_nxt;      // hole being walked
  logic [DW-1:0]   cur_r, cur_nxt;      // entry that moves through the heap
  result_t         res_r, res_nxt;

  // memory port
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [DW-1:0]   wr_data;
  logic [AW-1:0]   rd_a_addr, rd_b_addr;
  logic [DW-1:0]   rd_a_data, rd_b_data;

  logic            accept;
  logic            take;
  logic            full;
  logic [DW-1:0]   new_entry;

  // sift-up indexes
  logic [AW-1:0]   cnt_pos, cnt_par, pos_par, pos_gpar;
  logic            par_gt;

  // sift-down indexes and child pick
  logic [XW-1:0]   cnt_x, left_x, right_x, pick_x, next_left_x, next_right_x;
  logic            right_ok, pick_right, cur_gt, next_has;
  logic [DW-1:0]   pick_data;

  bmhq_entry_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // Handshake: a beat is taken only in idle with the result slot free
  // (or emptying this cycle), so a result can always be written when ready.
  assign take     = out_vld_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_vld_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign new_entry = {in_entry_key, TAG_BITS'(in_entry_tag)};

  // Sift-up: parent of the new slot, parent of the hole, and its parent.
  assign cnt_pos  = AW'(count_r);
  assign cnt_par  = (cnt_pos - AW'(1)) >> 1;
  assign pos_par  = (pos_r - AW'(1)) >> 1;
  assign pos_gpar = (pos_par - AW'(1)) >> 1;
  // port A holds the parent of the hole while walking up
  assign par_gt   = rd_a_data[DW-1 -: KEY_W] > cur_r[DW-1 -: KEY_W];

  // Sift-down: port A = left child, port B = right child of the hole.
  // Right wins only when it exists and is strictly smaller.
  assign cnt_x        = XW'(count_r);
  assign left_x       = XW'({pos_r, 1'b1});
  assign right_x      = left_x + XW'(1);
  assign right_ok     = right_x < cnt_x;
  assign pick_right   = right_ok &&
                        (rd_b_data[DW-1 -: KEY_W] < rd_a_data[DW-1 -: KEY_W]);
  assign pick_data    = pick_right ? rd_b_data : rd_a_data;
  assign pick_x       = pick_right ? right_x : left_x;
  assign cur_gt       = cur_r[DW-1 -: KEY_W] > pick_data[DW-1 -: KEY_W];
  assign next_left_x  = {pick_x[XW-2:0], 1'b1};
  assign next_right_x = next_left_x + XW'(1);
  assign next_has     = next_left_x < cnt_x;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    cur_nxt     = cur_r;
    out_vld_nxt = out_vld_r && !take;
    res_nxt     = res_r;
    wr_en       = 1'b0;
    wr_addr     = pos_r;
    wr_data     = cur_r;
    rd_a_addr   = '0;
    rd_b_addr   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_vld_nxt = 1'b1;
          res_nxt     = '0;
          if (in_opcode == OP_INSERT) begin
            if (full) begin
              res_nxt.dropped = 1'b1;
              res_nxt.fill    = FILL_W'(count_r);
            end else begin
              count_nxt    = count_r + CW'(1);
              res_nxt.fill = FILL_W'(count_r + CW'(1));
              cur_nxt      = new_entry;
              pos_nxt      = cnt_pos;
              if (count_r == '0) begin
                // empty heap: new entry is the root
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = new_entry;
              end else begin
                rd_a_addr = cnt_par;
                state_nxt = ST_UP;
              end
            end
          end else if (count_r != '0) begin
            // result is built in ST_EXT from the root read here
            out_vld_nxt = 1'b0;
            count_nxt   = count_r - CW'(1);
            rd_a_addr   = '0;
            rd_b_addr   = AW'(count_r - CW'(1));
            state_nxt   = ST_EXT;
          end
        end
      end

      ST_UP: begin
        if (par_gt) begin
          // parent moves down into the hole
          wr_en   = 1'b1;
          wr_data = rd_a_data;
          pos_nxt = pos_par;
          if (pos_par == '0) begin
            state_nxt = ST_UP_FIN;
          end else begin
            rd_a_addr = pos_gpar;
          end
        end else begin
          wr_en     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_UP_FIN: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_EXT: begin
        // port A = old root, port B = last entry; count already decremented
        out_vld_nxt     = 1'b1;
        res_nxt         = '0;
        res_nxt.found   = 1'b1;
        res_nxt.key     = rd_a_data[DW-1 -: KEY_W];
        res_nxt.tag     = TAG_W'(rd_a_data[TAG_BITS-1:0]);
        res_nxt.fill    = FILL_W'(count_r);
        cur_nxt         = rd_b_data;
        pos_nxt         = '0;
        if (count_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (count_r == CW'(1)) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = rd_b_data;
          state_nxt = ST_IDLE;
        end else begin
          rd_a_addr = AW'(1);
          rd_b_addr = AW'(2);
          state_nxt = ST_DN;
        end
      end

      ST_DN: begin
        if (cur_gt) begin
          // smaller child moves up into the hole
          wr_en   = 1'b1;
          wr_data = pick_data;
          pos_nxt = AW'(pick_x);
          if (next_has) begin
            rd_a_addr = AW'(next_left_x);
            rd_b_addr = AW'(next_right_x);
          end else begin
            state_nxt = ST_DN_FIN;
          end
        end else begin
          wr_en     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_DN_FIN: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_out_valid      = res_r.found;
  assign out_out_key        = res_r.key;
  assign out_out_tag        = res_r.tag;
  assign out_insert_dropped = res_r.dropped;
  assign out_fill_count     = res_r.fill;

endmodule

>>> design/bmhq_checker.sv
// Port-level checks for the binary min-heap queue, bound to the top level.
// Depends on bmhq_pkg.
module bmhq_checker #(
  parameter int DEPTH = 1024
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_out_valid,
  input logic [bmhq_pkg::KEY_W-1:0]    out_out_key,
  input logic [bmhq_pkg::TAG_W-1:0]    out_out_tag,
  input logic                          out_insert_dropped,
  input logic [bmhq_pkg::FILL_W-1:0]   out_fill_count
);

  import bmhq_pkg::*;

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_valid) &&
      $stable(out_out_key) && $stable(out_out_tag) &&
      $stable(out_insert_dropped) && $stable(out_fill_count))
    else $error("result beat changed while stalled");

  // no new beat is taken while a result is held
  a_stall_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  // an extract result is never also a refused insert
  a_found_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_valid |-> !out_insert_dropped)
    else $error("found and dropped together");

  // no entry returned means zero key and tag
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> (out_out_key == '0) && (out_out_tag == '0))
    else $error("nonzero payload without an entry");

  // a refused insert only happens with the heap full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_insert_dropped |-> out_fill_count == FILL_W'(DEPTH))
    else $error("insert refused below full");

endmodule

bind binary_min_heap_queue_unit bmhq_checker #(.DEPTH(DEPTH)) u_bmhq_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for binary_min_heap_queue_unit: insert / extract-min beats against a software heap.
// Depends on bmhq_pkg for opcode and result types and widths; needs only the RTL.
module tb;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH = 1024;
  localparam int HOLD_CYCLES = 24;   // longest heap walk plus margin

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_RUNS, STALL_HEAVY} stall_style_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_opcode = OP_INSERT;
  logic [KEY_W-1:0]  in_entry_key = '0;
  logic [TAG_W-1:0]  in_entry_tag = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_out_valid;
  logic [KEY_W-1:0]  out_out_key;
  logic [TAG_W-1:0]  out_out_tag;
  logic              out_insert_dropped;
  logic [FILL_W-1:0] out_fill_count;

  binary_min_heap_queue_unit #(
    .DEPTH(HEAP_DEPTH),
    .TAG_BITS(TAG_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_entry_key(in_entry_key),
    .in_entry_tag(in_entry_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_out_valid(out_out_valid),
    .out_out_key(out_out_key),
    .out_out_tag(out_out_tag),
    .out_insert_dropped(out_insert_dropped),
    .out_fill_count(out_fill_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Software heap mirror. Updated on every accepted input beat; each beat
  // yields exactly one expected result, queued in acceptance order.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] mirror_keys [HEAP_DEPTH];
  logic [TAG_W-1:0] mirror_tags [HEAP_DEPTH];
  int unsigned      mirror_fill = 0;
  result_t          heap_replies [$];
  result_t          reply_want;
  int unsigned      mismatches = 0;

  function automatic void mirror_swap(input int unsigned a, input int unsigned b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = mirror_keys[a];
    t = mirror_tags[a];
    mirror_keys[a] = mirror_keys[b];
    mirror_tags[a] = mirror_tags[b];
    mirror_keys[b] = k;
    mirror_tags[b] = t;
  endfunction

  // Apply one beat to the mirror and return the result the block owes for it.
  function automatic result_t heap_apply(input opcode_t op, input logic [KEY_W-1:0] k,
                                         input logic [TAG_W-1:0] t);
    result_t     r;
    int unsigned pos;
    int unsigned up;
    int unsigned lc;
    int unsigned pick;
    bit          done;
    r = '0;
    if (op == OP_INSERT) begin
      if (mirror_fill >= HEAP_DEPTH) begin
        r.dropped = 1'b1;   // full heap: refused, contents untouched
      end else begin
        pos = mirror_fill;
        mirror_keys[pos] = k;
        mirror_tags[pos] = t;
        mirror_fill++;
        done = 1'b0;
        // sift up; equal keys never swap
        while (pos > 0 && !done) begin
          up = (pos - 1) / 2;
          if (mirror_keys[up] > mirror_keys[pos]) begin
            mirror_swap(up, pos);
            pos = up;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else if (mirror_fill > 0) begin
      r.found = 1'b1;
      r.key = mirror_keys[0];
      r.tag = mirror_tags[0];
      mirror_fill--;
      mirror_keys[0] = mirror_keys[mirror_fill];
      mirror_tags[0] = mirror_tags[mirror_fill];
      pos = 0;
      done = 1'b0;
      // sift down; right child only when strictly smaller than left
      while (!done) begin
        lc = 2 * pos + 1;
        if (lc >= mirror_fill) begin
          done = 1'b1;
        end else begin
          pick = lc;
          if (lc + 1 < mirror_fill && mirror_keys[lc + 1] < mirror_keys[lc]) pick = lc + 1;
          if (mirror_keys[pos] > mirror_keys[pick]) begin
            mirror_swap(pos, pick);
            pos = pick;
          end else begin
            done = 1'b1;
          end
        end
      end
    end
    r.fill = mirror_fill[FILL_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Result checker and input monitor share one process: results are matched
  // first, then the beat taken at this edge (if any) is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (heap_replies.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result beat, expected none, got key %0h tag %0h",
                   $time, out_out_key, out_out_tag);
        end else begin
          reply_want = heap_replies.pop_front();
          check_field("out_valid", 32'(reply_want.found), 32'(out_out_valid));
          check_field("out_key", 32'(reply_want.key), 32'(out_out_key));
          check_field("out_tag", 32'(reply_want.tag), 32'(out_out_tag));
          check_field("insert_dropped", 32'(reply_want.dropped), 32'(out_insert_dropped));
          check_field("fill_count", 32'(reply_want.fill), 32'(out_fill_count));
        end
      end
      if (in_valid && !in_stall)
        heap_replies.push_back(heap_apply(opcode_t'(in_opcode), in_entry_key, in_entry_tag));
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver backpressure: switches between styles at random intervals, from no stall
  // at all to heavy stalling.
  // ---------------------------------------------------------------------------
  stall_style_t stall_style = STALL_NONE;
  int unsigned  stall_phase = 0;

  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_phase = $urandom_range(50, 300);
    end
    stall_phase--;
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
      STALL_RUNS:  out_stall <= stall_phase[3];
      default:     out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender: beats go out in bursts of random length with random gaps.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned stim_fill = 0;   // sender-side entry count, for steering the tests

  task automatic send_beat(input opcode_t op, input logic [KEY_W-1:0] k,
                           input logic [TAG_W-1:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      in_valid <= 1'b1;
    end
    in_opcode <= op;
    in_entry_key <= k;
    in_entry_tag <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
    if (op == OP_INSERT) begin
      if (stim_fill < HEAP_DEPTH) stim_fill++;
    end else if (stim_fill > 0) begin
      stim_fill--;
    end
  endtask

  task automatic end_burst();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  // Hold the sender until every owed result has come back.
  task automatic wait_idle();
    end_burst();
    @(posedge clk);
    while (heap_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Keys lean toward the ends of the range and toward small values for ties.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [31:0] word;
    word = $urandom();
    case ($urandom_range(0, 3))
      0:       word = $urandom_range(0, 15);
      1:       word = 32'h7fff_ffff - $urandom_range(0, 15);
      default: ;
    endcase
    return word[KEY_W-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    logic [31:0] word;
    word = $urandom();
    return word[TAG_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty extracts, key and tag extremes, and tie handling up and down.
  task automatic test_directed();
    send_beat(OP_EXTRACT, '1, '1);              // empty heap, ignored payload
    send_beat(OP_INSERT, '1, '1);
    send_beat(OP_INSERT, '0, '0);
    send_beat(OP_INSERT, '0, 16'h0001);         // tie with root, must not swap
    send_beat(OP_INSERT, '1, 16'h0001);
    repeat (4) send_beat(OP_EXTRACT, '0, '0);
    send_beat(OP_EXTRACT, '0, '0);              // empty again
    // equal children under the root: left child wins
    send_beat(OP_INSERT, 31'd1, 16'd10);
    send_beat(OP_INSERT, 31'd7, 16'd11);
    send_beat(OP_INSERT, 31'd7, 16'd12);
    send_beat(OP_INSERT, 31'd9, 16'd13);
    repeat (4) send_beat(OP_EXTRACT, pick_key(), pick_tag());
    // run of equal keys
    send_beat(OP_INSERT, 31'd3, 16'd20);
    send_beat(OP_INSERT, 31'd3, 16'd21);
    send_beat(OP_INSERT, 31'd3, 16'd22);
    repeat (3) send_beat(OP_EXTRACT, '0, '1);
    wait_idle();
  endtask

  // Random insert / extract mix around a small, shifting heap.
  task automatic test_random_mix();
    int unsigned bias;
    repeat (250) begin
      bias = $urandom_range(0, 99);
      if (bias < 57) send_beat(OP_INSERT, pick_key(), pick_tag());
      else send_beat(OP_EXTRACT, pick_key(), pick_tag());
      if ($urandom_range(0, 59) == 0) wait_idle();
    end
    wait_idle();
  endtask

  // Grow the heap to capacity, then work the full boundary.
  task automatic test_fill_to_full();
    int unsigned n;
    logic [KEY_W-1:0] k;
    n = 0;
    while (stim_fill < HEAP_DEPTH) begin
      // every third key descends from the top of the range; the rest are random
      k = (n % 3 == 0) ? KEY_W'(32'h7fff_ffff - n) : pick_key();
      send_beat(OP_INSERT, k, pick_tag());
      n++;
    end
    repeat (6) send_beat(OP_INSERT, pick_key(), pick_tag());   // refused
    repeat (20) begin
      send_beat(OP_EXTRACT, pick_key(), pick_tag());
      send_beat(OP_INSERT, pick_key(), pick_tag());
    end
    repeat (3) send_beat(OP_INSERT, pick_key(), pick_tag());   // refused again
    wait_idle();
  endtask

  // Deep sift-downs from a nearly full heap, with some refills.
  task automatic test_deep_extract();
    repeat (100) begin
      if ($urandom_range(0, 3) == 0) send_beat(OP_INSERT, pick_key(), pick_tag());
      else send_beat(OP_EXTRACT, pick_key(), pick_tag());
    end
    end_burst();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix();
    test_fill_to_full();
    test_deep_extract();
    @(posedge clk);
    while (heap_replies.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("binary_min_heap_queue_unit test passed");
    end else begin
      $display("binary_min_heap_queue_unit test failed");
    end
    $finish;
  end

  // Watchdog: reports failure and stops if the run has not finished.
  initial begin
    #5_000_000;
    $display("binary_min_heap_queue_unit test failed");
    $finish;
  end

endmodule
